/* rtl/core/dmrc_pkg.sv */
// Shared types and codes of the direct-mapped read cache.
`default_nettype none

package dmrc_pkg;

    localparam int ADDR_BITS        = 32;
    localparam int NUM_LINES_DEF    = 8;
    localparam int LINE_SIZE_DEF    = 32;
    localparam int BEAT_BYTES       = 8;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_FILL  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] ST_HIT   = 3'd0;
    localparam logic [2:0] ST_MISS  = 3'd1;
    localparam logic [2:0] ST_BEAT  = 3'd2;
    localparam logic [2:0] ST_DONE  = 3'd3;
    localparam logic [2:0] ST_ERR   = 3'd4;

    typedef struct packed {
        logic [1:0]           operation;
        logic [ADDR_BITS-1:0] address;
        logic [1:0]           fill_beat;
        logic [63:0]          fill_data;
    } t_in;

    typedef struct packed {
        logic [2:0]           status;
        logic [7:0]           data_byte;
        logic [ADDR_BITS-1:0] request_address;
        logic [31:0]          hit_total;
        logic [31:0]          miss_total;
    } t_out;

endpackage

`default_nettype wire

/* rtl/core/direct_mapped_read_cache.sv */
// Direct-mapped read cache with line fill by 64-bit beats.
//
// One item enters per cycle unless the output stalls, and its result leaves
// through an input register, whose data word is read from the line store at
// the same edge, then one pass of tag check and state update into the result
// register. Every item gives exactly one result. The line store is one 64-bit
// wide memory read once and written once per cycle; a fill beat written in
// the cycle a read issues is forwarded. A read that misses asks for the line;
// while that fill is pending, reads are refused with an error status until
// the last beat arrives. NUM_LINES and LINE_SIZE are powers of two.
`default_nettype none

module direct_mapped_read_cache #(
    parameter int NUM_LINES = dmrc_pkg::NUM_LINES_DEF,
    parameter int LINE_SIZE = dmrc_pkg::LINE_SIZE_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire dmrc_pkg::t_in i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output dmrc_pkg::t_out     o_out_data
);

    localparam int AW      = dmrc_pkg::ADDR_BITS;
    localparam int OFF_W   = $clog2(LINE_SIZE);
    localparam int IDX_W   = $clog2(NUM_LINES);
    localparam int TAG_W   = AW - IDX_W - OFF_W;
    localparam int BEATS   = LINE_SIZE / dmrc_pkg::BEAT_BYTES;
    localparam int BCNT_W  = (OFF_W > 3) ? OFF_W - 3 : 1;
    localparam int WIDX_W  = IDX_W + OFF_W - 3;
    localparam int NUM_WORDS = NUM_LINES * BEATS;

    logic [63:0]        r_mem [NUM_WORDS];
    logic [63:0]        r_rd_word;

    logic               r_in_valid;
    dmrc_pkg::t_in      r_in;
    logic               r_out_valid;
    dmrc_pkg::t_out     r_out;

    logic [NUM_LINES-1:0] r_line_valid;
    logic [TAG_W-1:0]   r_tag [NUM_LINES];
    logic               r_pending;
    logic [AW-1:0]      r_pend_addr;
    logic [BCNT_W-1:0]  r_next_beat;
    logic [7:0]         r_pend_byte;
    logic [31:0]        r_hits;
    logic [31:0]        r_misses;

    logic               accept;
    logic               move;
    logic [WIDX_W-1:0]  rd_idx;
    logic [WIDX_W-1:0]  wr_idx;
    logic               mem_we;

    logic [IDX_W-1:0]   rd_line;
    logic [TAG_W-1:0]   rd_tag;
    logic [IDX_W-1:0]   pend_line;
    logic [BCNT_W-1:0]  pend_word;
    logic [7:0]         pend_lane_byte;
    logic               beat_ok;
    logic               beat_last;
    logic               word_match;

    dmrc_pkg::t_out     n_out;
    logic [NUM_LINES-1:0] n_line_valid;
    logic               n_pending;
    logic [BCNT_W-1:0]  n_next_beat;
    logic               tag_we;
    logic               pend_we;
    logic               byte_we;

    assign move        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !move;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign rd_idx    = i_in_data.address[IDX_W+OFF_W-1:3];
    assign rd_line   = r_in.address[IDX_W+OFF_W-1:OFF_W];
    assign rd_tag    = r_in.address[AW-1:IDX_W+OFF_W];
    assign pend_line = r_pend_addr[IDX_W+OFF_W-1:OFF_W];
    assign pend_word = BCNT_W'(r_pend_addr[OFF_W-1:0] >> 3);
    assign pend_lane_byte = r_in.fill_data[8*r_pend_addr[2:0] +: 8];
    assign wr_idx    = (WIDX_W'(pend_line) << (OFF_W - 3)) | WIDX_W'(r_next_beat);
    assign beat_ok   = r_pending && (32'(r_in.fill_beat) == 32'(r_next_beat));
    assign beat_last = (r_next_beat == BCNT_W'(BEATS - 1));
    assign word_match = (r_next_beat == pend_word);
    assign mem_we    = move && (r_in.operation == dmrc_pkg::OP_FILL) && beat_ok;

    always_comb begin
        n_out                 = '0;
        n_out.status          = dmrc_pkg::ST_ERR;
        n_out.hit_total       = r_hits;
        n_out.miss_total      = r_misses;
        n_line_valid          = r_line_valid;
        n_pending             = r_pending;
        n_next_beat           = r_next_beat;
        tag_we                = 1'b0;
        pend_we               = 1'b0;
        byte_we               = 1'b0;
        case (r_in.operation)
            dmrc_pkg::OP_READ: begin
                if (!r_pending) begin
                    if (r_line_valid[rd_line] && r_tag[rd_line] == rd_tag) begin
                        n_out.status    = dmrc_pkg::ST_HIT;
                        n_out.data_byte = r_rd_word[8*r_in.address[2:0] +: 8];
                        n_out.hit_total = r_hits + 32'd1;
                    end else begin
                        n_out.status          = dmrc_pkg::ST_MISS;
                        n_out.miss_total      = r_misses + 32'd1;
                        n_out.request_address = r_in.address
                                                & ~AW'(LINE_SIZE - 1);
                        n_line_valid[rd_line] = 1'b0;
                        n_pending             = 1'b1;
                        n_next_beat           = '0;
                        pend_we               = 1'b1;
                    end
                end
            end
            dmrc_pkg::OP_FILL: begin
                if (beat_ok) begin
                    byte_we = word_match;
                    if (beat_last) begin
                        n_out.status            = dmrc_pkg::ST_DONE;
                        n_out.data_byte         = word_match ? pend_lane_byte
                                                             : r_pend_byte;
                        n_line_valid[pend_line] = 1'b1;
                        tag_we                  = 1'b1;
                        n_pending               = 1'b0;
                        n_next_beat             = '0;
                    end else begin
                        n_out.status = dmrc_pkg::ST_BEAT;
                        n_next_beat  = r_next_beat + BCNT_W'(1);
                    end
                end
            end
            dmrc_pkg::OP_CLEAR: begin
                n_out.status     = dmrc_pkg::ST_BEAT;
                n_out.hit_total  = '0;
                n_out.miss_total = '0;
                n_line_valid     = '0;
                n_pending        = 1'b0;
                n_next_beat      = '0;
            end
            default: begin
                n_out.status = dmrc_pkg::ST_ERR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_idx] <= r_in.fill_data;
        end
        if (accept) begin
            r_rd_word <= (mem_we && wr_idx == rd_idx) ? r_in.fill_data : r_mem[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_data;
        end
        if (move) begin
            r_out <= n_out;
            if (tag_we) begin
                r_tag[pend_line] <= r_pend_addr[AW-1:IDX_W+OFF_W];
            end
            if (pend_we) begin
                r_pend_addr <= r_in.address;
            end
            if (byte_we) begin
                r_pend_byte <= pend_lane_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_line_valid <= '0;
            r_pending    <= 1'b0;
            r_next_beat  <= '0;
            r_hits       <= '0;
            r_misses     <= '0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid  <= 1'b1;
                r_line_valid <= n_line_valid;
                r_pending    <= n_pending;
                r_next_beat  <= n_next_beat;
                r_hits       <= n_out.hit_total;
                r_misses     <= n_out.miss_total;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/dmrc_checker.sv */
// Port-level checks of the direct-mapped read cache, bound to the top level.
`default_nettype none

module dmrc_checker #(
    parameter int LINE_SIZE = dmrc_pkg::LINE_SIZE_DEF
) (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           o_in_stall,
    input wire dmrc_pkg::t_in  i_in_data,
    input wire logic           o_out_valid,
    input wire logic           i_out_stall,
    input wire dmrc_pkg::t_out o_out_data
);

    localparam int OFF_W = $clog2(LINE_SIZE);

    logic out_xfer;
    logic in_xfer;

    assign out_xfer = o_out_valid && !i_out_stall;
    assign in_xfer  = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with the result side free");

    a_req_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == dmrc_pkg::ST_MISS
        |-> o_out_data.request_address[OFF_W-1:0] == '0)
        else $error("fill request not line aligned");

    a_no_hit_after_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && o_out_data.status == dmrc_pkg::ST_MISS
        |=> !(o_out_valid && o_out_data.status == dmrc_pkg::ST_HIT))
        else $error("hit while a fill is pending");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> ##1 o_out_valid)
        else $error("accepted transfer gave no result");

endmodule

bind direct_mapped_read_cache dmrc_checker #(.LINE_SIZE(LINE_SIZE)) u_dmrc_checker (.*);

`default_nettype wire
